@@ rtl/core/rcfd_pkg.sv @@
package rcfd_pkg;

    localparam int unsigned FrameLen = 18;
    localparam int unsigned CellCount = FrameLen - 1;
    localparam int unsigned CountW = 5;
    localparam int unsigned ChanW = 11;
    localparam int unsigned StickW = 12;
    localparam int unsigned CfgDataW = 11;
    localparam int unsigned CfgIndexW = 2;

    localparam logic [CfgIndexW-1:0] CfgCenterOffset = 2'd0;
    localparam logic [CfgIndexW-1:0] CfgStickLimit = 2'd1;
    localparam logic [CfgIndexW-1:0] CfgSwitchDown = 2'd2;

    localparam logic [ChanW-1:0] CenterOffsetReset = 11'd1024;
    localparam logic [ChanW-1:0] StickLimitReset = 11'd660;
    localparam logic [1:0] SwitchDownReset = 2'd2;

    typedef logic [FrameLen-1:0][7:0] frame_t;

    typedef struct packed {
        logic [ChanW-1:0] center_offset;
        logic [ChanW-1:0] stick_limit;
        logic [1:0]       switch_down_code;
    } cfg_t;

    typedef struct packed {
        logic signed [StickW-1:0] stick_right_h;
        logic signed [StickW-1:0] stick_right_v;
        logic signed [StickW-1:0] stick_left_h;
        logic signed [StickW-1:0] stick_left_v;
        logic signed [15:0]       wheel;
        logic [5:0]               buttons;
        logic signed [15:0]       mouse_x;
        logic signed [15:0]       mouse_y;
        logic signed [15:0]       mouse_z;
        logic [15:0]              keys;
        logic [15:0]              key_rising;
        logic                     frame_error;
    } result_t;

endpackage

@@ rtl/core/rcfd_byte_cell.sv @@
module rcfd_byte_cell (
    input  logic       clk,
    input  logic       shift,
    input  logic [7:0] din,
    output logic [7:0] dout
);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        data_next = shift ? din : data_reg;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign dout = data_reg;

endmodule

@@ rtl/core/rcfd_decode.sv @@
module rcfd_decode (
    input  rcfd_pkg::frame_t  frame,
    input  rcfd_pkg::cfg_t    cfg,
    input  logic [15:0]       prev_keys,
    output rcfd_pkg::result_t result
);

    logic [rcfd_pkg::ChanW-1:0]         raw [4];
    logic signed [rcfd_pkg::StickW-1:0] ctr [4];
    logic [3:0]                         over;
    logic signed [rcfd_pkg::StickW-1:0] lim_pos;
    logic signed [rcfd_pkg::StickW-1:0] lim_neg;
    logic [1:0]                         sw0;
    logic [1:0]                         sw1;
    logic [15:0]                        wheel_raw;
    logic                               err;
    logic [15:0]                        keys_final;

    always_comb
    begin
        raw[0] = {frame[1][2:0], frame[0]};
        raw[1] = {frame[2][5:0], frame[1][7:3]};
        raw[2] = {frame[4][0], frame[3], frame[2][7:6]};
        raw[3] = {frame[5][3:0], frame[4][7:1]};
        lim_pos = $signed({1'b0, cfg.stick_limit});
        lim_neg = -lim_pos;
        for (int i = 0; i < 4; i++)
        begin
            ctr[i] = $signed({1'b0, raw[i]}) - $signed({1'b0, cfg.center_offset});
            over[i] = (ctr[i] > lim_pos) || (ctr[i] < lim_neg);
        end
        sw0 = frame[5][5:4];
        sw1 = frame[5][7:6];
        wheel_raw = {frame[17], frame[16]} - {5'd0, cfg.center_offset};
        err = (|over) || (sw0 == 2'd0) || (sw1 == 2'd0);
        keys_final = err ? 16'd0 : {frame[15], frame[14]};

        result.stick_right_h = err ? '0 : ctr[0];
        result.stick_right_v = err ? '0 : ctr[1];
        result.stick_left_h = err ? '0 : ctr[2];
        result.stick_left_v = err ? '0 : ctr[3];
        result.wheel = err ? '0 : $signed(wheel_raw);
        if (err)
        begin
            result.buttons = {2'b00, cfg.switch_down_code, cfg.switch_down_code};
        end
        else
        begin
            result.buttons = {|frame[13], |frame[12], sw1, sw0};
        end
        result.mouse_x = err ? '0 : $signed({frame[7], frame[6]});
        result.mouse_y = err ? '0 : $signed({frame[9], frame[8]});
        result.mouse_z = err ? '0 : $signed({frame[11], frame[10]});
        result.keys = keys_final;
        result.key_rising = keys_final & ~prev_keys;
        result.frame_error = err;
    end

endmodule

@@ rtl/core/rc_receiver_frame_decoder_unit.sv @@
// Decodes 18-byte remote-control receiver frames arriving one byte per beat, with
// frame_start marking byte 0. The bytes run through a chain of byte cells, and the
// frame is decoded combinationally at the beat that carries its last byte, so the
// result is in the output register in the next cycle. A byte is accepted every cycle;
// only a frame-completing byte waits while an earlier result is still unread.
// Bytes after a complete frame without a start flag are dropped.
module rc_receiver_frame_decoder_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          rx_byte,
    input  logic                                frame_start,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [rcfd_pkg::StickW-1:0]  stick_right_h,
    output logic signed [rcfd_pkg::StickW-1:0]  stick_right_v,
    output logic signed [rcfd_pkg::StickW-1:0]  stick_left_h,
    output logic signed [rcfd_pkg::StickW-1:0]  stick_left_v,
    output logic signed [15:0]                  wheel,
    output logic [5:0]                          buttons,
    output logic signed [15:0]                  mouse_x,
    output logic signed [15:0]                  mouse_y,
    output logic signed [15:0]                  mouse_z,
    output logic [15:0]                         keys,
    output logic [15:0]                         key_rising,
    output logic                                frame_error,
    input  logic                                cfg_write,
    input  logic [rcfd_pkg::CfgIndexW-1:0]      cfg_index,
    input  logic [rcfd_pkg::CfgDataW-1:0]       cfg_data
);

    localparam logic [rcfd_pkg::CountW-1:0] LastIdx =
        rcfd_pkg::CountW'(rcfd_pkg::FrameLen - 1);
    localparam logic [rcfd_pkg::CountW-1:0] FullCount =
        rcfd_pkg::CountW'(rcfd_pkg::FrameLen);

    rcfd_pkg::cfg_t                 cfg_reg;
    rcfd_pkg::cfg_t                 cfg_next;
    logic [rcfd_pkg::CountW-1:0]    count_reg;
    logic [rcfd_pkg::CountW-1:0]    count_next;
    logic [15:0]                    prev_keys_reg;
    logic [15:0]                    prev_keys_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    rcfd_pkg::result_t              result_reg;
    rcfd_pkg::result_t              result_next;

    logic [7:0]                     cell_q [rcfd_pkg::CellCount];
    logic                           completes;
    logic                           store;
    logic                           accept;
    logic                           load;
    rcfd_pkg::frame_t               frame;
    rcfd_pkg::result_t              decoded;

    assign completes = !frame_start && (count_reg == LastIdx);
    assign in_ready = !out_valid_reg || out_ready || !completes;
    assign accept = in_valid && in_ready;
    assign store = accept && (frame_start || (count_reg < FullCount));
    assign load = store && completes;

    genvar g;
    generate
        for (g = 0; g < rcfd_pkg::CellCount; g++)
        begin : g_cell
            if (g == rcfd_pkg::CellCount - 1)
            begin : g_last
                rcfd_byte_cell u_cell (
                    .clk   (clk),
                    .shift (store),
                    .din   (rx_byte),
                    .dout  (cell_q[g])
                );
            end
            else
            begin : g_mid
                rcfd_byte_cell u_cell (
                    .clk   (clk),
                    .shift (store),
                    .din   (cell_q[g+1]),
                    .dout  (cell_q[g])
                );
            end
            assign frame[g] = cell_q[g];
        end
    endgenerate

    assign frame[rcfd_pkg::FrameLen-1] = rx_byte;

    rcfd_decode u_decode (
        .frame     (frame),
        .cfg       (cfg_reg),
        .prev_keys (prev_keys_reg),
        .result    (decoded)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                rcfd_pkg::CfgCenterOffset: cfg_next.center_offset = cfg_data;
                rcfd_pkg::CfgStickLimit:   cfg_next.stick_limit = cfg_data;
                rcfd_pkg::CfgSwitchDown:   cfg_next.switch_down_code = cfg_data[1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (store)
        begin
            count_next = frame_start ? rcfd_pkg::CountW'(1) : count_reg + 1'b1;
        end
        prev_keys_next = load ? decoded.keys : prev_keys_reg;
        result_next = load ? decoded : result_reg;
        out_valid_next = load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_offset <= rcfd_pkg::CenterOffsetReset;
            cfg_reg.stick_limit <= rcfd_pkg::StickLimitReset;
            cfg_reg.switch_down_code <= rcfd_pkg::SwitchDownReset;
            count_reg <= '0;
            prev_keys_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            count_reg <= count_next;
            prev_keys_reg <= prev_keys_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign stick_right_h = result_reg.stick_right_h;
    assign stick_right_v = result_reg.stick_right_v;
    assign stick_left_h = result_reg.stick_left_h;
    assign stick_left_v = result_reg.stick_left_v;
    assign wheel = result_reg.wheel;
    assign buttons = result_reg.buttons;
    assign mouse_x = result_reg.mouse_x;
    assign mouse_y = result_reg.mouse_y;
    assign mouse_z = result_reg.mouse_z;
    assign keys = result_reg.keys;
    assign key_rising = result_reg.key_rising;
    assign frame_error = result_reg.frame_error;

endmodule

@@ dv/rc_receiver_frame_decoder_checker.sv @@
module rc_receiver_frame_decoder_checker
    import rcfd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [7:0]                 rx_byte,
    input  logic                       frame_start,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic signed [StickW-1:0]   stick_right_h,
    input  logic signed [StickW-1:0]   stick_right_v,
    input  logic signed [StickW-1:0]   stick_left_h,
    input  logic signed [StickW-1:0]   stick_left_v,
    input  logic signed [15:0]         wheel,
    input  logic [5:0]                 buttons,
    input  logic signed [15:0]         mouse_x,
    input  logic signed [15:0]         mouse_y,
    input  logic signed [15:0]         mouse_z,
    input  logic [15:0]                keys,
    input  logic [15:0]                key_rising,
    input  logic                       frame_error,
    input  logic                       cfg_write,
    input  logic [CfgIndexW-1:0]       cfg_index,
    input  logic [CfgDataW-1:0]        cfg_data,
    output int unsigned                fail_count,
    output int unsigned                pending
);

    localparam int unsigned ReportLimit = 10;

    cfg_t        active_cfg;
    frame_t      frame_store;
    int unsigned bytes_held;
    logic [15:0] last_keys;
    result_t     decoded_q[$];
    int unsigned fails = 0;

    function automatic result_t decode_frame(input frame_t fb, input cfg_t c,
                                             input logic [15:0] prior_keys);
        result_t     r;
        logic [47:0] head;
        int          stick [4];
        logic [1:0]  sw_l;
        logic [1:0]  sw_r;
        logic        rejected;
        head = fb[5:0];
        sw_l = head[45:44];
        sw_r = head[47:46];
        rejected = (sw_l == 2'd0) || (sw_r == 2'd0);
        for (int i = 0; i < 4; i++)
        begin
            stick[i] = int'(head[11*i +: 11]) - int'(c.center_offset);
            if ((stick[i] < 0 ? -stick[i] : stick[i]) > int'(c.stick_limit))
            begin
                rejected = 1'b1;
            end
        end
        r = '0;
        if (rejected)
        begin
            r.buttons = {2'b00, c.switch_down_code, c.switch_down_code};
            r.frame_error = 1'b1;
        end
        else
        begin
            r.stick_right_h = 12'(stick[0]);
            r.stick_right_v = 12'(stick[1]);
            r.stick_left_h = 12'(stick[2]);
            r.stick_left_v = 12'(stick[3]);
            r.wheel = fb[17:16] - 16'(c.center_offset);
            r.buttons = {|fb[13], |fb[12], sw_r, sw_l};
            r.mouse_x = fb[7:6];
            r.mouse_y = fb[9:8];
            r.mouse_z = fb[11:10];
            r.keys = fb[15:14];
        end
        r.key_rising = r.keys & ~prior_keys;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            fails++;
            if (fails <= ReportLimit)
            begin
                $display("%s mismatch: expected %h, got %h", field, want, got);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        if (!rst_n)
        begin
            active_cfg = '{CenterOffsetReset, StickLimitReset, SwitchDownReset};
            bytes_held = 0;
            last_keys = '0;
            decoded_q.delete();
        end
        else
        begin
            // Each result beat is matched against the oldest decoded frame.
            if (out_valid && out_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    fails++;
                    if (fails <= ReportLimit)
                    begin
                        $display("result beat with no completed frame outstanding");
                    end
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("stick_right_h", want.stick_right_h, stick_right_h);
                    check_field("stick_right_v", want.stick_right_v, stick_right_v);
                    check_field("stick_left_h", want.stick_left_h, stick_left_h);
                    check_field("stick_left_v", want.stick_left_v, stick_left_v);
                    check_field("wheel", want.wheel, wheel);
                    check_field("buttons", want.buttons, buttons);
                    check_field("mouse_x", want.mouse_x, mouse_x);
                    check_field("mouse_y", want.mouse_y, mouse_y);
                    check_field("mouse_z", want.mouse_z, mouse_z);
                    check_field("keys", want.keys, keys);
                    check_field("key_rising", want.key_rising, key_rising);
                    check_field("frame_error", want.frame_error, frame_error);
                end
            end
            if (in_valid && in_ready)
            begin
                if (frame_start)
                begin
                    bytes_held = 0;
                end
                if (frame_start || bytes_held < FrameLen)
                begin
                    frame_store[bytes_held] = rx_byte;
                    bytes_held++;
                    if (bytes_held == FrameLen)
                    begin
                        want = decode_frame(frame_store, active_cfg, last_keys);
                        last_keys = want.keys;
                        decoded_q.push_back(want);
                    end
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CfgCenterOffset: active_cfg.center_offset = cfg_data;
                    CfgStickLimit:   active_cfg.stick_limit = cfg_data;
                    CfgSwitchDown:   active_cfg.switch_down_code = cfg_data[1:0];
                    default:         ;
                endcase
            end
        end
        fail_count <= fails;
        pending <= decoded_q.size();
    end

endmodule

@@ dv/tb_rc_receiver_frame_decoder_unit.sv @@
module tb_rc_receiver_frame_decoder_unit;

    import rcfd_pkg::*;

    localparam logic [CfgIndexW-1:0] CfgNoReg = 2'd3;
    localparam int ChanMax = (1 << ChanW) - 1;
    localparam int PhaseCount = 9;
    localparam int ItemTarget = 1350;
    localparam int SettleCycles = 4;
    localparam int DrainCycles = 20;
    localparam int LongHold = 400;
    localparam int unsigned CycleLimit = 500000;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [7:0]               rx_byte;
    logic                     frame_start;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [StickW-1:0] stick_right_h;
    logic signed [StickW-1:0] stick_right_v;
    logic signed [StickW-1:0] stick_left_h;
    logic signed [StickW-1:0] stick_left_v;
    logic signed [15:0]       wheel;
    logic [5:0]               buttons;
    logic signed [15:0]       mouse_x;
    logic signed [15:0]       mouse_y;
    logic signed [15:0]       mouse_z;
    logic [15:0]              keys;
    logic [15:0]              key_rising;
    logic                     frame_error;
    logic                     cfg_write;
    logic [CfgIndexW-1:0]     cfg_index;
    logic [CfgDataW-1:0]      cfg_data;
    int unsigned              fail_count;
    int unsigned              pending;

    int          cur_offset;
    int          cur_limit;
    bit          sender_gaps = 1'b0;
    bit          receiver_gaps = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned cycles = 0;

    rc_receiver_frame_decoder_unit DUT (.*);

    rc_receiver_frame_decoder_checker checker_i (.*);

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [10:0] pick_stick();
        int raw;
        case ($urandom_range(0, 9))
            0:       raw = cur_offset - cur_limit;
            1:       raw = cur_offset + cur_limit;
            2:       raw = $urandom_range(0, ChanMax);
            default: raw = cur_offset + int'($urandom_range(0, 2 * cur_limit)) - cur_limit;
        endcase
        if (raw < 0) raw = 0;
        if (raw > ChanMax) raw = ChanMax;
        return 11'(raw);
    endfunction

    function automatic frame_t pack_frame(input logic [43:0] sticks, input logic [3:0] switches,
                                          input logic [95:0] tail);
        frame_t fb;
        fb[5:0] = {switches, sticks};
        fb[17:6] = tail;
        return fb;
    endfunction

    function automatic frame_t random_frame();
        logic [43:0] sticks;
        logic [3:0]  switches;
        logic [95:0] tail;
        for (int i = 0; i < 4; i++)
        begin
            sticks[11*i +: 11] = pick_stick();
        end
        for (int i = 0; i < 2; i++)
        begin
            switches[2*i +: 2] = ($urandom_range(0, 11) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
        end
        tail = {$urandom, $urandom, $urandom};
        if ($urandom_range(0, 1) == 0)
        begin
            tail[55:48] = 8'h00;
        end
        if ($urandom_range(0, 1) == 0)
        begin
            tail[63:56] = 8'h00;
        end
        return pack_frame(sticks, switches, tail);
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic start);
        int unsigned gap;
        in_valid <= 1'b1;
        rx_byte <= value;
        frame_start <= start;
        do @(posedge clk); while (!in_ready);
        gap = sender_gaps ? pick_gap() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_frame(input frame_t fb, input logic flagged, input int count);
        for (int i = 0; i < count; i++)
        begin
            send_byte(fb[i], flagged && i == 0);
        end
    endtask

    task automatic apply_settings(input int offset, input int limit, input int code);
        cfg_write <= 1'b1;
        cfg_index <= CfgCenterOffset;
        cfg_data <= 11'(offset);
        @(posedge clk);
        cfg_index <= CfgStickLimit;
        cfg_data <= 11'(limit);
        @(posedge clk);
        cfg_index <= CfgSwitchDown;
        cfg_data <= {9'($urandom), 2'(code)};
        @(posedge clk);
        cfg_index <= CfgNoReg;
        cfg_data <= 11'($urandom);
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_offset = offset;
        cur_limit = limit;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin : watchdog
        while (cycles < CycleLimit)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : receiver
        int unsigned span;
        bit          hold_served;
        hold_served = 1'b0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request && !hold_served)
            begin
                hold_served = 1'b1;
                out_ready <= 1'b0;
                span = LongHold;
            end
            else if (receiver_gaps && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                span = pick_gap() + 1;
            end
            else
            begin
                out_ready <= 1'b1;
                span = $urandom_range(1, 8);
            end
            repeat (span) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        frame_t fb;
        int     n;
        int     roll;
        int     phase_items;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        rx_byte <= '0;
        frame_start <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= CfgCenterOffset;
        cfg_data <= '0;
        cur_offset = CenterOffsetReset;
        cur_limit = StickLimitReset;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A frame without a start flag right after reset, with sticks at both limits.
        send_frame(pack_frame({11'd1684, 11'd1024, 11'd364, 11'd1684}, {2'd1, 2'd3},
                              {16'h0000, 16'hFFFF, 8'h01, 8'h80, 16'hFFFF, 16'h7FFF, 16'h8000}),
                   1'b0, FrameLen);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_frame(random_frame(), 1'b1, 4);

        for (int phase = 0; phase < PhaseCount; phase++)
        begin
            if (phase != 0)
            begin
                in_valid <= 1'b0;
                do @(posedge clk); while (pending != 0);
                repeat (SettleCycles) @(posedge clk);
                case (phase)
                    1:       apply_settings(0, ChanMax, 0);
                    2:       apply_settings(ChanMax, 0, 3);
                    3:       apply_settings(512, 660, 1);
                    4:       apply_settings(ChanMax, ChanMax, 2);
                    5:       apply_settings(0, 0, 3);
                    default: apply_settings($urandom_range(0, ChanMax), $urandom_range(0, ChanMax),
                                            $urandom_range(0, 3));
                endcase
            end
            sender_gaps = (phase != 1) && ($urandom_range(0, 3) != 0);
            receiver_gaps = (phase != 1) && ($urandom_range(0, 3) != 0);
            if (phase == 3)
            begin
                sender_gaps = 1'b0;
                hold_request = 1'b1;
            end
            phase_items = 0;
            while (phase_items < ItemTarget / PhaseCount)
            begin
                fb = random_frame();
                roll = $urandom_range(0, 99);
                if (roll < 70)
                begin
                    send_frame(fb, 1'b1, FrameLen);
                    phase_items += FrameLen;
                end
                else if (roll < 80)
                begin
                    n = $urandom_range(1, FrameLen - 1);
                    send_frame(fb, 1'b1, n);
                    phase_items += n;
                end
                else if (roll < 88)
                begin
                    send_frame(fb, 1'b1, FrameLen);
                    phase_items += FrameLen;
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
                end
                else if (roll < 95)
                begin
                    for (int i = 0; i < FrameLen; i++)
                    begin
                        fb[i] = 8'($urandom);
                    end
                    send_frame(fb, 1'b1, FrameLen);
                    phase_items += FrameLen;
                end
                else
                begin
                    n = $urandom_range(1, 5);
                    repeat (n) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
                    phase_items += n;
                end
            end
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DrainCycles) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
